[rtl/sivu_pkg.sv]
package sivu_pkg;

    localparam int CAPACITY_DEF = 32;
    localparam int COORD_W      = 16;
    localparam int OP_W         = 2;
    localparam int INDEX_W      = 5;
    localparam int COUNT_OUT_W  = 6;
    localparam int IN_DATA_W    = 40;
    localparam int OUT_DATA_W   = 40;

    localparam logic [COORD_W-1:0] MIN_WIDTH_RST = 16'd1;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_CLEAR  = 2'd1,
        OP_READ   = 2'd2,
        OP_NOP    = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        CMD_HOLD,
        CMD_CLEAR,
        CMD_INSERT,
        CMD_COLLAPSE,
        CMD_MERGE
    } cell_cmd_t;

    typedef enum logic {
        ST_IDLE,
        ST_WORK
    } state_t;

    typedef struct packed {
        logic                      valid;
        logic signed [COORD_W-1:0] left;
        logic signed [COORD_W-1:0] right;
    } entry_t;

    typedef struct packed {
        logic bef;   // stored interval ends at or before the new left end
        logic ovl;   // stored interval strictly overlaps the new span
        logic head;  // first cell that is not before: where the new span lands
    } cell_flags_t;

endpackage

[rtl/sivu_cell.sv]
module sivu_cell (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  sivu_pkg::cell_cmd_t                      cmd,
    input  logic signed [sivu_pkg::COORD_W-1:0]      span_left,
    input  logic signed [sivu_pkg::COORD_W-1:0]      span_right,
    input  sivu_pkg::entry_t                         prev_entry,
    input  sivu_pkg::entry_t                         next_entry,
    input  logic                                     prev_bef,
    input  logic                                     next_ovl,
    output sivu_pkg::entry_t                         entry,
    output sivu_pkg::cell_flags_t                    flags
);

    logic                                 valid_reg;
    logic                                 valid_next;
    logic signed [sivu_pkg::COORD_W-1:0]  left_reg;
    logic signed [sivu_pkg::COORD_W-1:0]  left_next;
    logic signed [sivu_pkg::COORD_W-1:0]  right_reg;
    logic signed [sivu_pkg::COORD_W-1:0]  right_next;
    logic                                 bef;
    logic                                 ovl;
    logic                                 head;
    logic                                 after;

    // Sorted and disjoint, so the "before" cells form a prefix and the
    // overlapping cells a run straight after it.
    assign bef   = valid_reg && (right_reg <= span_left);
    assign ovl   = valid_reg && !bef && (left_reg < span_right);
    assign head  = !bef && prev_bef;
    assign after = !prev_bef;

    assign flags = '{bef: bef, ovl: ovl, head: head};
    assign entry = '{valid: valid_reg, left: left_reg, right: right_reg};

    always_comb
    begin
        valid_next = valid_reg;
        left_next  = left_reg;
        right_next = right_reg;
        case (cmd)
            sivu_pkg::CMD_CLEAR:
            begin
                valid_next = 1'b0;
            end
            sivu_pkg::CMD_INSERT:
            begin
                if (head)
                begin
                    valid_next = 1'b1;
                    left_next  = span_left;
                    right_next = span_right;
                end
                else if (after)
                begin
                    valid_next = prev_entry.valid;
                    left_next  = prev_entry.left;
                    right_next = prev_entry.right;
                end
            end
            sivu_pkg::CMD_COLLAPSE:
            begin
                // absorb the next overlapping neighbour, pull the tail down
                if (head && next_ovl)
                begin
                    right_next = next_entry.right;
                end
                else if (after)
                begin
                    valid_next = next_entry.valid;
                    left_next  = next_entry.left;
                    right_next = next_entry.right;
                end
            end
            sivu_pkg::CMD_MERGE:
            begin
                if (head)
                begin
                    left_next  = (span_left < left_reg) ? span_left : left_reg;
                    right_next = (span_right > right_reg) ? span_right : right_reg;
                end
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        left_reg  <= left_next;
        right_reg <= right_next;
    end

endmodule

[rtl/sorted_interval_union_insert_top.sv]
// Sorted interval union: keeps up to CAPACITY disjoint intervals on a signed
// 16-bit line, sorted by left end, one interval per cell of a cell chain.
// Input beats (s_axis_*) carry an op: insert [span_left, span_right], clear
// the list, or read the entry at read_index. Every input beat gives exactly
// one output beat (m_axis_*) with the entry count after the op, the overflow
// flag and the read result.
// Configuration: a beat on cfg_* writes min_width; write only while idle.
// Sequencing: one beat is taken, then worked on alone. Clear, read, ignored
// or dropped inserts and inserts that overlap at most one stored interval
// have their result registered in the work state that follows accept, once
// the output register is free; an insert that merges k stored intervals
// first collapses the chain one neighbour per cycle, then merges. The next
// beat is accepted in the cycle after the result is registered.
// Reset empties the list (all cell valid bits cleared at once, no sweep) and
// sets min_width to 1.
// Stall: a result waits in the output register; a new beat is still taken,
// its collapse steps run, and its final step holds until the waiting result
// has gone.
module sorted_interval_union_insert_top #(
    parameter int CAPACITY = sivu_pkg::CAPACITY_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [1:0] op, [17:2] span_left, [33:18] span_right, [38:34] read_index
    input  logic [sivu_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [5:0] entry_count, [6] overflow, [7] read_valid,
    // [23:8] read_left, [39:24] read_right
    output logic [sivu_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [sivu_pkg::COORD_W-1:0]       cfg_data
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IW    = (CNT_W > sivu_pkg::INDEX_W) ? CNT_W : sivu_pkg::INDEX_W;

    sivu_pkg::state_t                       state_reg;
    sivu_pkg::state_t                       state_next;
    sivu_pkg::op_t                          op_reg;
    logic signed [sivu_pkg::COORD_W-1:0]    left_reg;
    logic signed [sivu_pkg::COORD_W-1:0]    right_reg;
    logic [sivu_pkg::INDEX_W-1:0]           idx_reg;
    logic [CNT_W-1:0]                       count_reg;
    logic [CNT_W-1:0]                       count_next;
    logic [sivu_pkg::COORD_W-1:0]           minw_reg;
    logic                                   m_valid_reg;
    logic [sivu_pkg::OUT_DATA_W-1:0]        m_data_reg;
    logic [sivu_pkg::OUT_DATA_W-1:0]        m_data_next;

    sivu_pkg::cell_cmd_t                    cmd;
    sivu_pkg::entry_t                       cell_entry [CAPACITY];
    sivu_pkg::cell_flags_t                  cell_flags [CAPACITY];
    logic [CAPACITY-1:0]                    valid_vec;
    logic [CAPACITY-1:0]                    ovl_vec;
    logic [CAPACITY-1:0]                    more_vec;

    logic                                   s_accept;
    logic                                   done;
    logic                                   ovf;
    logic                                   any_ovl;
    logic                                   more;
    logic                                   full;
    logic                                   can_finish;
    logic signed [sivu_pkg::COORD_W:0]      span_diff;
    logic                                   ignore_span;
    logic [IW-1:0]                          idx_w;
    logic                                   rd_valid;
    logic signed [sivu_pkg::COORD_W-1:0]    rd_left;
    logic signed [sivu_pkg::COORD_W-1:0]    rd_right;

    assign s_accept  = s_axis_tvalid && s_axis_tready;
    assign cfg_ready = 1'b1;

    // ---------------- cell chain ----------------
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        sivu_pkg::entry_t prev_e;
        sivu_pkg::entry_t next_e;
        logic             prev_b;
        logic             next_o;

        if (i == 0)
        begin : g_first
            assign prev_e = '0;
            assign prev_b = 1'b1;
        end
        else
        begin : g_mid
            assign prev_e = cell_entry[i-1];
            assign prev_b = cell_flags[i-1].bef;
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign next_e = '0;
            assign next_o = 1'b0;
        end
        else
        begin : g_inner
            assign next_e = cell_entry[i+1];
            assign next_o = cell_flags[i+1].ovl;
        end

        sivu_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cmd        (cmd),
            .span_left  (left_reg),
            .span_right (right_reg),
            .prev_entry (prev_e),
            .next_entry (next_e),
            .prev_bef   (prev_b),
            .next_ovl   (next_o),
            .entry      (cell_entry[i]),
            .flags      (cell_flags[i])
        );

        assign valid_vec[i] = cell_entry[i].valid;
        assign ovl_vec[i]   = cell_flags[i].ovl;
        assign more_vec[i]  = cell_flags[i].head && next_o;
    end

    // ---------------- span checks ----------------
    assign span_diff   = {right_reg[sivu_pkg::COORD_W-1], right_reg}
                       - {left_reg[sivu_pkg::COORD_W-1], left_reg};
    assign ignore_span = span_diff[sivu_pkg::COORD_W]
                       || (span_diff[sivu_pkg::COORD_W-1:0] < minw_reg);
    assign any_ovl     = |ovl_vec;
    assign more        = |more_vec;
    assign full        = (count_reg == CNT_W'(CAPACITY));
    assign can_finish  = !m_valid_reg || m_axis_tready;

    // ---------------- read port ----------------
    assign idx_w    = IW'(idx_reg);
    assign rd_valid = (op_reg == sivu_pkg::OP_READ) && (idx_w < IW'(count_reg));

    always_comb
    begin
        rd_left  = '0;
        rd_right = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (rd_valid && (idx_w == IW'(i)))
            begin
                rd_left  = cell_entry[i].left;
                rd_right = cell_entry[i].right;
            end
        end
    end

    // ---------------- next state ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sivu_pkg::ST_IDLE:
            begin
                if (s_accept)
                begin
                    state_next = sivu_pkg::ST_WORK;
                end
            end
            sivu_pkg::ST_WORK:
            begin
                if (done)
                begin
                    state_next = sivu_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sivu_pkg::ST_IDLE;
            end
        endcase
    end

    // ---------------- outputs of the sequencer ----------------
    always_comb
    begin
        s_axis_tready = (state_reg == sivu_pkg::ST_IDLE);
        cmd           = sivu_pkg::CMD_HOLD;
        done          = 1'b0;
        ovf           = 1'b0;
        count_next    = count_reg;
        if (state_reg == sivu_pkg::ST_WORK)
        begin
            case (op_reg)
                sivu_pkg::OP_INSERT:
                begin
                    if (ignore_span)
                    begin
                        done = can_finish;
                    end
                    else if (any_ovl && more)
                    begin
                        // fold one neighbour into the head cell, keep going
                        cmd        = sivu_pkg::CMD_COLLAPSE;
                        count_next = count_reg - CNT_W'(1);
                    end
                    else if (can_finish)
                    begin
                        done = 1'b1;
                        if (any_ovl)
                        begin
                            cmd = sivu_pkg::CMD_MERGE;
                        end
                        else if (full)
                        begin
                            ovf = 1'b1;
                        end
                        else
                        begin
                            cmd        = sivu_pkg::CMD_INSERT;
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                end
                sivu_pkg::OP_CLEAR:
                begin
                    if (can_finish)
                    begin
                        done       = 1'b1;
                        cmd        = sivu_pkg::CMD_CLEAR;
                        count_next = '0;
                    end
                end
                default:
                begin
                    done = can_finish;
                end
            endcase
        end
    end

    // Pack the result beat.
    always_comb
    begin
        m_data_next        = '0;
        m_data_next[5:0]   = sivu_pkg::COUNT_OUT_W'(count_next);
        m_data_next[6]     = ovf;
        m_data_next[7]     = rd_valid;
        m_data_next[23:8]  = rd_left;
        m_data_next[39:24] = rd_right;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= sivu_pkg::ST_IDLE;
            count_reg   <= '0;
            minw_reg    <= sivu_pkg::MIN_WIDTH_RST;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (cfg_valid && cfg_ready)
            begin
                minw_reg <= cfg_data;
            end
            if (done)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Hold the beat's payload while it is worked on.
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            op_reg    <= sivu_pkg::op_t'(s_axis_tdata[1:0]);
            left_reg  <= s_axis_tdata[17:2];
            right_reg <= s_axis_tdata[33:18];
            idx_reg   <= s_axis_tdata[38:34];
        end
        if (done)
        begin
            m_data_reg <= m_data_next;
        end
    end

    // ---------------- assertions ----------------
    a_count_matches_cells: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_vec) == int'(count_reg))
        else $error("stored count disagrees with occupied cells");

    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        int'(count_reg) <= CAPACITY)
        else $error("stored count above capacity");

    a_overflow_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        (done && ovf) |-> full)
        else $error("overflow flagged on a list with room");

    a_collapse_needs_two: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd == sivu_pkg::CMD_COLLAPSE) |-> (count_reg >= CNT_W'(2)))
        else $error("collapse with fewer than two stored intervals");

    a_done_clears_state: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> (state_reg == sivu_pkg::ST_IDLE) && m_valid_reg)
        else $error("finished item left no result or sequencer busy");

endmodule

[tb/span_list_checker.sv]
`timescale 1ns / 1ps

// Watches the input, output and min_width channels of the interval list,
// keeps its own copy of the list and compares every output beat against it.
module span_list_checker #(
    parameter int CAPACITY = sivu_pkg::CAPACITY_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    input  logic                              s_axis_tready,
    // [1:0] op, [17:2] span_left, [33:18] span_right, [38:34] read_index
    input  logic [sivu_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    input  logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [5:0] entry_count, [6] overflow, [7] read_valid,
    // [23:8] read_left, [39:24] read_right
    input  logic [sivu_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    input  logic                              cfg_valid,
    input  logic                              cfg_ready,
    input  logic [sivu_pkg::COORD_W-1:0]      cfg_data,
    output int                                fail_count,
    output int                                results_due,
    output int                                results_seen,
    output int                                overflows_seen
);

    localparam int COORD_W     = sivu_pkg::COORD_W;
    localparam int INDEX_W     = sivu_pkg::INDEX_W;
    localparam int COUNT_OUT_W = sivu_pkg::COUNT_OUT_W;
    localparam int IN_DATA_W   = sivu_pkg::IN_DATA_W;
    localparam int OUT_DATA_W  = sivu_pkg::OUT_DATA_W;
    // Results still owed by the block; it never holds more than two.
    localparam int PEND_DEPTH  = 8;

    typedef struct packed {
        logic [COUNT_OUT_W-1:0]    entry_count;
        logic                      overflow;
        logic                      read_valid;
        logic signed [COORD_W-1:0] read_left;
        logic signed [COORD_W-1:0] read_right;
    } span_result_t;

    logic signed [COORD_W-1:0] span_lo [CAPACITY];
    logic signed [COORD_W-1:0] span_hi [CAPACITY];
    int unsigned               span_count = 0;
    logic [COORD_W-1:0]        min_span   = sivu_pkg::MIN_WIDTH_RST;
    span_result_t              pend_res [PEND_DEPTH];
    int                        pend_wr    = 0;
    int                        pend_rd    = 0;

    // Merge [lo, hi] into the list; return 1 when it is dropped for lack of room.
    function automatic logic add_span(input logic signed [COORD_W-1:0] lo,
                                      input logic signed [COORD_W-1:0] hi);
        int                        pos;
        int                        k;
        int                        n;
        int                        i;
        logic signed [COORD_W-1:0] new_lo;
        logic signed [COORD_W-1:0] new_hi;
        pos    = 0;
        k      = 0;
        n      = int'(span_count);
        new_lo = lo;
        new_hi = hi;
        if (hi < lo)
            return 1'b0;
        if (int'(hi) - int'(lo) < int'(min_span))
            return 1'b0;
        while (pos < n && span_hi[pos] <= lo)
            pos++;
        while (pos + k < n && span_lo[pos + k] < hi)
            k++;
        if (k == 0)
        begin
            if (n >= CAPACITY)
                return 1'b1;
            for (i = n; i > pos; i--)
            begin
                span_lo[i] = span_lo[i - 1];
                span_hi[i] = span_hi[i - 1];
            end
            span_count = unsigned'(n + 1);
        end
        else
        begin
            if (span_lo[pos] < new_lo)
                new_lo = span_lo[pos];
            if (span_hi[pos + k - 1] > new_hi)
                new_hi = span_hi[pos + k - 1];
            for (i = pos + 1; i + k - 1 < n; i++)
            begin
                span_lo[i] = span_lo[i + k - 1];
                span_hi[i] = span_hi[i + k - 1];
            end
            span_count = unsigned'(n - k + 1);
        end
        span_lo[pos] = new_lo;
        span_hi[pos] = new_hi;
        return 1'b0;
    endfunction

    function automatic span_result_t predict_result(input logic [IN_DATA_W-1:0] beat);
        sivu_pkg::op_t        op;
        logic [INDEX_W-1:0]   idx;
        span_result_t         res;
        op  = sivu_pkg::op_t'(beat[1:0]);
        idx = beat[38:34];
        res = '0;
        case (op)
            sivu_pkg::OP_INSERT: res.overflow = add_span(beat[17:2], beat[33:18]);
            sivu_pkg::OP_CLEAR:  span_count = 0;
            sivu_pkg::OP_READ:
                if (idx < span_count)
                begin
                    res.read_valid = 1'b1;
                    res.read_left  = span_lo[idx];
                    res.read_right = span_hi[idx];
                end
            default: ;
        endcase
        res.entry_count = COUNT_OUT_W'(span_count);
        return res;
    endfunction

    task automatic check_field(input string field, input logic [COORD_W-1:0] want,
                               input logic [COORD_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track
        span_result_t          want;
        logic [OUT_DATA_W-1:0] got;
        if (!rst_n)
        begin
            span_count  = 0;
            min_span    = sivu_pkg::MIN_WIDTH_RST;
            pend_wr     = 0;
            pend_rd     = 0;
            results_due = 0;
        end
        else
        begin
            // Output first: a beat leaving now belongs to an older item.
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata;
                if (pend_wr == pend_rd)
                begin
                    $display("%0t: unexpected output beat, expected none, got %h",
                             $time, got);
                    fail_count++;
                end
                else
                begin
                    want = pend_res[pend_rd % PEND_DEPTH];
                    pend_rd++;
                    results_seen++;
                    check_field("entry_count", COORD_W'(want.entry_count),
                                COORD_W'(got[5:0]));
                    check_field("overflow", COORD_W'(want.overflow), COORD_W'(got[6]));
                    check_field("read_valid", COORD_W'(want.read_valid), COORD_W'(got[7]));
                    check_field("read_left", want.read_left, got[23:8]);
                    check_field("read_right", want.read_right, got[39:24]);
                end
            end
            if (cfg_valid && cfg_ready)
                min_span = cfg_data;
            if (s_axis_tvalid && s_axis_tready)
            begin
                want = predict_result(s_axis_tdata);
                if (want.overflow)
                    overflows_seen++;
                if (pend_wr - pend_rd >= PEND_DEPTH)
                begin
                    $display("%0t: too many results owed, expected at most %0d, got %0d",
                             $time, PEND_DEPTH, pend_wr - pend_rd + 1);
                    fail_count++;
                end
                else
                begin
                    pend_res[pend_wr % PEND_DEPTH] = want;
                    pend_wr++;
                end
            end
            results_due = pend_wr - pend_rd;
        end
    end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps

// Stimulus and verdict for the sorted interval list. All prediction and
// comparison lives in span_list_checker; this module only drives beats.
module tb_top;

    localparam int COORD_W        = sivu_pkg::COORD_W;
    localparam int INDEX_W        = sivu_pkg::INDEX_W;
    localparam int IN_DATA_W      = sivu_pkg::IN_DATA_W;
    localparam int OUT_DATA_W     = sivu_pkg::OUT_DATA_W;

    localparam int CLK_PERIOD     = 4;
    localparam int RESET_CYCLES   = 5;
    localparam int WATCHDOG_LIMIT = 4000;
    // Room within which random spans land, narrow enough for the list to fill.
    localparam int WIN_SPAN       = 1500;
    // Worst case here is a 32-way merge; allow it plenty of slack at the end.
    localparam int SETTLE_CYCLES  = 80;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b1;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  cfg_valid     = 1'b0;
    logic                  cfg_ready;
    logic [COORD_W-1:0]    cfg_data      = '0;

    int fail_count;
    int results_due;
    int results_seen;
    int overflows_seen;

    // Stimulus controls and run counters; quiet also gates the output stall process.
    bit quiet      = 1'b0;
    int gap_pct    = 20;
    int win_base   = 0;
    int cur_min    = 1;
    int items_sent = 0;
    int settings   = 1;
    int idle_run   = 0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    sorted_interval_union_insert_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    span_list_checker u_span_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .fail_count     (fail_count),
        .results_due    (results_due),
        .results_seen   (results_seen),
        .overflows_seen (overflows_seen)
    );

    // Watchdog: end the run if no channel moves a beat for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            idle_run <= 0;
        else if (idle_run >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog: no beat moved for %0d cycles, %0d results still due",
                     idle_run, results_due);
            $display("TB_ERROR");
            $finish;
        end
        else
            idle_run <= idle_run + 1;
    end

    // Output back-pressure: now and then drop tready for a random stretch, with
    // random open stretches between them; hold it high once the run is quiet.
    initial
    begin
        @(posedge clk);
        forever
        begin
            if (!quiet && $urandom_range(0, 3) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
                m_axis_tready <= 1'b1;
            end
            repeat ($urandom_range(1, 24)) @(posedge clk);
        end
    end

    // Offer one input beat and hold it until taken. tvalid stays high on
    // return so that a following beat can go out back to back.
    task automatic send_beat(input sivu_pkg::op_t op,
                             input logic signed [COORD_W-1:0] lo,
                             input logic signed [COORD_W-1:0] hi,
                             input logic [INDEX_W-1:0] idx);
        if (!quiet && $urandom_range(0, 99) < gap_pct)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, idx, hi, lo, op};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        items_sent++;
    endtask

    // Drop tvalid and wait until every result has come back.
    task automatic drain;
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        wait (results_due == 0);
        @(posedge clk);
    endtask

    task automatic write_min_width(input int value);
        cfg_valid <= 1'b1;
        cfg_data  <= COORD_W'(value);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        cur_min = value;
        settings++;
    endtask

    // Move the window of random spans somewhere new on the line.
    task automatic pick_window;
        win_base = int'($urandom_range(0, 65535 - WIN_SPAN)) - 32768;
    endtask

    // Mostly well-formed inserts inside the window with reads between them;
    // now and then clears, unused ops, reversed and full-line spans.
    task automatic run_random(input int count);
        int                        sel;
        int                        lo_i;
        int                        hi_i;
        int                        w;
        sivu_pkg::op_t             op;
        logic signed [COORD_W-1:0] lo;
        logic signed [COORD_W-1:0] hi;
        logic [INDEX_W-1:0]        idx;
        pick_window();
        repeat (count)
        begin
            sel = $urandom_range(0, 199);
            lo  = COORD_W'($urandom);
            hi  = COORD_W'($urandom);
            idx = $urandom_range(0, 1) ? INDEX_W'($urandom_range(0, 7))
                                       : INDEX_W'($urandom_range(0, 31));
            if (sel < 8)
                op = sivu_pkg::OP_NOP;
            else if (sel < 11)
            begin
                op = sivu_pkg::OP_CLEAR;
                pick_window();
            end
            else if (sel < 61)
                op = sivu_pkg::OP_READ;
            else
            begin
                op  = sivu_pkg::OP_INSERT;
                sel = $urandom_range(0, 99);
                if (sel < 6)
                    ;   // keep the raw random ends, often reversed
                else if (sel < 9)
                begin
                    lo = 16'sh8000;
                    hi = 16'sh7fff;
                end
                else if (sel < 14)
                begin
                    // reversed span: swap so the right end is the smaller
                    if (lo < hi)
                        {lo, hi} = {hi, lo};
                    if (lo == hi)
                        hi = lo - 1'b1;
                end
                else
                begin
                    sel = $urandom_range(0, 99);
                    if (sel < 10)
                        w = 0;
                    else if (sel < 35)
                        w = $urandom_range(0, 3000);
                    else
                        w = cur_min + int'($urandom_range(0, 40));
                    lo_i = win_base + int'($urandom_range(0, WIN_SPAN));
                    hi_i = lo_i + w;
                    if (hi_i > 32767)
                        hi_i = 32767;
                    lo = COORD_W'(lo_i);
                    hi = COORD_W'(hi_i);
                end
            end
            send_beat(op, lo, hi, idx);
        end
    endtask

    initial
    begin
        int phase_min [5];
        int phase_len [5];
        int p;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opening at the reset min_width of 1.
        send_beat(sivu_pkg::OP_READ, 16'sd0, 16'sd0, 5'd0);          // read on an empty list
        send_beat(sivu_pkg::OP_NOP, -16'sd1, -16'sd1, 5'd31);        // unused op, all ones
        send_beat(sivu_pkg::OP_INSERT, 16'sd10, -16'sd10, 5'd0);     // reversed span
        send_beat(sivu_pkg::OP_INSERT, 16'sd7, 16'sd7, 5'd0);        // too narrow
        send_beat(sivu_pkg::OP_INSERT, 16'sh8000, -16'sd30000, 5'd0);
        send_beat(sivu_pkg::OP_INSERT, 16'sd30000, 16'sh7fff, 5'd0);
        send_beat(sivu_pkg::OP_INSERT, -16'sd100, 16'sd100, 5'd0);
        send_beat(sivu_pkg::OP_INSERT, 16'sd100, 16'sd200, 5'd0);    // touches, stays apart
        send_beat(sivu_pkg::OP_INSERT, -16'sd200, -16'sd100, 5'd0);  // touches on the left
        send_beat(sivu_pkg::OP_INSERT, -16'sd150, 16'sd150, 5'd0);   // swallows all three
        for (p = 0; p < 4; p++)
            send_beat(sivu_pkg::OP_READ, 16'sd0, 16'sd0, INDEX_W'(p));
        send_beat(sivu_pkg::OP_READ, 16'sd0, 16'sd0, 5'd31);
        send_beat(sivu_pkg::OP_INSERT, -16'sd30000, 16'sd30000, 5'd0); // touches both ends
        send_beat(sivu_pkg::OP_CLEAR, 16'sd0, 16'sd0, 5'd0);
        send_beat(sivu_pkg::OP_READ, 16'sd0, 16'sd0, 5'd0);
        send_beat(sivu_pkg::OP_INSERT, 16'sh8000, 16'sh7fff, 5'd0);  // whole line
        send_beat(sivu_pkg::OP_READ, 16'sd0, 16'sd0, 5'd0);
        send_beat(sivu_pkg::OP_INSERT, 16'sd0, 16'sd1, 5'd0);
        run_random(380);

        // Zero min_width: points are stored and never merge with equal points.
        drain();
        write_min_width(0);
        send_beat(sivu_pkg::OP_CLEAR, 16'sd0, 16'sd0, 5'd0);
        send_beat(sivu_pkg::OP_INSERT, 16'sd5, 16'sd5, 5'd0);
        send_beat(sivu_pkg::OP_INSERT, 16'sd5, 16'sd5, 5'd0);
        send_beat(sivu_pkg::OP_INSERT, 16'sd4, 16'sd6, 5'd0);
        send_beat(sivu_pkg::OP_READ, 16'sd0, 16'sd0, 5'd0);

        // Remaining settings, the upper extreme among them; the last phase
        // runs with no idling on either side.
        phase_min = '{0, int'($urandom_range(2, 60)), 65535, 1000, 1};
        phase_len = '{380, 380, 120, 300, 380};
        for (p = 0; p < 5; p++)
        begin
            if (p > 0)
            begin
                drain();
                write_min_width(phase_min[p]);
            end
            gap_pct = $urandom_range(5, 40);
            quiet   = (p == 4);
            run_random(phase_len[p]);
        end

        // Wait out the last results, then give the block time to misbehave.
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d input beats under %0d min_width settings; checked %0d results.",
                 items_sent, settings, results_seen);
        $display("%0d inserts were dropped on a full list.", overflows_seen);
        if (fail_count == 0 && results_due == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
